// ===== rtl/core/button_driven_velocity_ramp_fsm_top_macros.svh =====
// Assertion macros for the velocity ramp controller.
// Included by the top level, which carries concurrent checks; SYNTH strips them.
`ifndef BUTTON_DRIVEN_VELOCITY_RAMP_FSM_TOP_MACROS_SVH
`define BUTTON_DRIVEN_VELOCITY_RAMP_FSM_TOP_MACROS_SVH
`ifndef SYNTH
// Check that holds outside reset.
`define BDVR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that also holds across reset.
`define BDVR_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDVR_ASSERT(lbl, clk, rstn, prop, msg)
`define BDVR_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/bdvr_pkg.sv =====
// Shared types and constants for the velocity ramp controller.
// No dependencies; used by bdvr_step and the top level.
package bdvr_pkg;

  localparam logic [2:0] MODE_INIT     = 3'd0;
  localparam logic [2:0] MODE_IDLE     = 3'd1;
  localparam logic [2:0] MODE_FORWARD  = 3'd2;
  localparam logic [2:0] MODE_STOP     = 3'd3;
  localparam logic [2:0] MODE_BACKWARD = 3'd4;

  localparam logic [1:0] CFG_ACCEL   = 2'd0;
  localparam logic [1:0] CFG_DECEL   = 2'd1;
  localparam logic [1:0] CFG_HOLDOFF = 2'd2;

  localparam logic [14:0] ACCEL_RESET   = 15'd1638;
  localparam logic [14:0] DECEL_RESET   = 15'd328;
  localparam logic [15:0] HOLDOFF_RESET = 16'd250;

  localparam logic signed [15:0] FULL_SCALE = 16'sd16384;
  localparam logic signed [2:0]  STEER_FULL = 3'sd2;
  localparam logic signed [2:0]  STEER_HALF = 3'sd1;

  // prev_levels bit positions
  localparam int LVL_B    = 0;
  localparam int LVL_UP   = 1;
  localparam int LVL_DOWN = 2;
  // pending_edges bit positions
  localparam int PEND_UP   = 0;
  localparam int PEND_DOWN = 1;

  typedef struct packed {
    logic [7:0] elapsed_ms;
    logic       right_level;
    logic       left_level;
    logic       down_level;
    logic       up_level;
    logic       b_level;
    logic       a_level;
  } item_t;

  typedef struct packed {
    logic [14:0] accel_step;
    logic [14:0] decel_step;
    logic [15:0] holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] speed;
    logic signed [15:0] shadow_speed;
    logic signed [2:0]  steer;
    logic               swap_flag;
    logic [15:0]        hold_timer;
    logic [2:0]         prev_levels;
    logic [1:0]         pending_edges;
  } state_t;

endpackage

// ===== rtl/core/bdvr_step.sv =====
// Next-state logic for one control tick of the velocity ramp controller.
// Depends on bdvr_pkg; purely combinational.
module bdvr_step (
  input  bdvr_pkg::cfg_t   cfg,
  input  bdvr_pkg::item_t  item,
  input  bdvr_pkg::state_t cur,
  output bdvr_pkg::state_t nxt
);

  localparam logic signed [17:0] FULL_W = 18'sd16384;
  localparam logic signed [17:0] NEG_FULL_W = -18'sd16384;

  logic signed [17:0] acc_w;
  logic signed [17:0] dec_w;
  logic signed [17:0] base_w;
  logic signed [17:0] sum_w;
  logic signed [17:0] shd_w;
  logic [16:0]        hold_sum;
  logic [2:0]         lv;
  logic [2:0]         rise;
  logic [1:0]         pend;

  always_comb begin
    acc_w    = signed'({3'b000, cfg.accel_step});
    dec_w    = signed'({3'b000, cfg.decel_step});
    hold_sum = {1'b0, cur.hold_timer} + {9'd0, item.elapsed_ms};
    lv       = {item.down_level, item.up_level, item.b_level};
    rise     = lv & ~cur.prev_levels;
    pend     = cur.pending_edges;
    if (rise[bdvr_pkg::LVL_UP])   pend[bdvr_pkg::PEND_UP]   = 1'b1;
    if (rise[bdvr_pkg::LVL_DOWN]) pend[bdvr_pkg::PEND_DOWN] = 1'b1;

    nxt               = cur;
    nxt.prev_levels   = lv;
    nxt.hold_timer    = hold_sum[16] ? 16'hFFFF : hold_sum[15:0];
    nxt.swap_flag     = cur.swap_flag ^ rise[bdvr_pkg::LVL_B];
    base_w            = 18'(cur.speed);
    sum_w             = base_w;
    shd_w             = 18'(cur.shadow_speed);

    unique case (cur.mode)
      bdvr_pkg::MODE_INIT: begin
        nxt.mode = bdvr_pkg::MODE_IDLE;
      end
      bdvr_pkg::MODE_IDLE: begin
        if (item.right_level)     nxt.steer = bdvr_pkg::STEER_FULL;
        else if (item.left_level) nxt.steer = -bdvr_pkg::STEER_FULL;
        else                      nxt.steer = '0;
        // up edge wins over down edge; both latches are consumed
        if (pend[bdvr_pkg::PEND_DOWN]) nxt.mode = bdvr_pkg::MODE_BACKWARD;
        if (pend[bdvr_pkg::PEND_UP])   nxt.mode = bdvr_pkg::MODE_FORWARD;
        pend = '0;
        if (item.a_level) begin
          nxt.speed = bdvr_pkg::FULL_SCALE;
          nxt.mode  = bdvr_pkg::MODE_FORWARD;
        end
      end
      bdvr_pkg::MODE_FORWARD: begin
        if (item.a_level) base_w = FULL_W;
        if (item.up_level) begin
          sum_w     = base_w + acc_w;
          nxt.speed = (sum_w > FULL_W) ? bdvr_pkg::FULL_SCALE : sum_w[15:0];
        end else begin
          sum_w     = base_w - dec_w;
          nxt.speed = (sum_w < 0) ? '0 : sum_w[15:0];
        end
        if (nxt.speed == '0)   nxt.mode  = bdvr_pkg::MODE_IDLE;
        if (item.right_level)  nxt.steer = bdvr_pkg::STEER_HALF;
        if (item.left_level)   nxt.steer = -bdvr_pkg::STEER_HALF;
        if (pend[bdvr_pkg::PEND_DOWN]) begin
          pend[bdvr_pkg::PEND_DOWN] = 1'b0;
          nxt.speed        = '0;
          nxt.steer        = '0;
          nxt.shadow_speed = '0;
          nxt.hold_timer   = '0;
          nxt.mode         = bdvr_pkg::MODE_STOP;
        end
      end
      bdvr_pkg::MODE_STOP: begin
        if (item.down_level && (nxt.hold_timer < cfg.holdoff_ms)) begin
          shd_w            = shd_w - dec_w;
          nxt.shadow_speed = (shd_w < NEG_FULL_W) ? -bdvr_pkg::FULL_SCALE : shd_w[15:0];
        end else if (item.down_level) begin
          nxt.speed = cur.shadow_speed;
          nxt.mode  = bdvr_pkg::MODE_BACKWARD;
        end else begin
          nxt.mode = bdvr_pkg::MODE_IDLE;
        end
      end
      bdvr_pkg::MODE_BACKWARD: begin
        if (item.a_level) begin
          base_w   = FULL_W;
          nxt.mode = bdvr_pkg::MODE_FORWARD;
        end
        if (item.down_level) begin
          sum_w     = base_w - acc_w;
          nxt.speed = (sum_w < NEG_FULL_W) ? -bdvr_pkg::FULL_SCALE : sum_w[15:0];
        end else begin
          sum_w     = base_w + dec_w;
          nxt.speed = (sum_w > 0) ? '0 : sum_w[15:0];
        end
        if (nxt.speed == '0)   nxt.mode  = bdvr_pkg::MODE_IDLE;
        if (item.right_level)  nxt.steer = bdvr_pkg::STEER_HALF;
        if (item.left_level)   nxt.steer = -bdvr_pkg::STEER_HALF;
        if (pend[bdvr_pkg::PEND_UP]) begin
          pend[bdvr_pkg::PEND_UP] = 1'b0;
          nxt.speed = '0;
          nxt.steer = '0;
          nxt.mode  = bdvr_pkg::MODE_FORWARD;
        end
      end
      default: begin
        nxt.mode = bdvr_pkg::MODE_IDLE;
      end
    endcase

    nxt.pending_edges = pend;
  end

endmodule

// ===== rtl/core/button_driven_velocity_ramp_fsm_top.sv =====
// Velocity ramp controller: input register, one-tick step logic, result register.
// Throughput: one tick per cycle while out_tready is high.
// Limit: the result register; while a result waits the input register takes one more
// transaction and then holds in_tready low.
// Reset (rst_n low, synchronous): mode init, all state zero, step registers to defaults.
// Depends on bdvr_pkg, bdvr_step and the assertion macro header.
`include "button_driven_velocity_ramp_fsm_top_macros.svh"
module button_driven_velocity_ramp_fsm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] a_level, [1] b_level, [2] up_level, [3] down_level, [4] left_level,
  // [5] right_level, [13:6] elapsed_ms, [15:14] zero
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] velocity_out, [18:16] steer_out, [19] front_swapped,
  // [22:20] mode_out, [23] zero
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  bdvr_pkg::cfg_t   cfg_r;
  bdvr_pkg::item_t  item_r;
  logic             item_valid_r;
  bdvr_pkg::state_t st_r;
  bdvr_pkg::state_t st_nxt;
  logic             out_valid_r;
  logic [23:0]      out_data_r;
  logic             adv;
  logic             in_fire;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !item_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_step <= bdvr_pkg::ACCEL_RESET;
      cfg_r.decel_step <= bdvr_pkg::DECEL_RESET;
      cfg_r.holdoff_ms <= bdvr_pkg::HOLDOFF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        bdvr_pkg::CFG_ACCEL:   cfg_r.accel_step <= cfg_data[14:0];
        bdvr_pkg::CFG_DECEL:   cfg_r.decel_step <= cfg_data[14:0];
        bdvr_pkg::CFG_HOLDOFF: cfg_r.holdoff_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the input item until the result register can take its result
  always_ff @(posedge clk) begin
    if (in_fire) item_r <= bdvr_pkg::item_t'(in_tdata[13:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_fire) begin
      item_valid_r <= 1'b1;
    end else if (adv) begin
      item_valid_r <= 1'b0;
    end
  end

  bdvr_step u_step (
    .cfg  (cfg_r),
    .item (item_r),
    .cur  (st_r),
    .nxt  (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= item_valid_r;
      if (item_valid_r) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_valid_r) begin
      out_data_r <= {1'b0, st_nxt.mode, st_nxt.swap_flag, st_nxt.steer, st_nxt.speed};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `BDVR_ASSERT_ANY(a_reset_init, clk,
    !rst_n |=> (st_r.mode == bdvr_pkg::MODE_INIT) && !out_tvalid && !item_valid_r,
    "reset did not return to init with empty pipeline")
  `BDVR_ASSERT(a_still_modes, clk, rst_n,
    (st_r.mode == bdvr_pkg::MODE_IDLE || st_r.mode == bdvr_pkg::MODE_STOP) |->
      (st_r.speed == '0),
    "velocity nonzero in idle or stop")
  `BDVR_ASSERT(a_vel_range, clk, rst_n,
    out_tvalid |-> ($signed(out_tdata[15:0]) <= bdvr_pkg::FULL_SCALE) &&
      ($signed(out_tdata[15:0]) >= -bdvr_pkg::FULL_SCALE),
    "velocity out of range")
  `BDVR_ASSERT(a_bwd_sign, clk, rst_n,
    out_tvalid && (out_tdata[22:20] == bdvr_pkg::MODE_BACKWARD) |->
      ($signed(out_tdata[15:0]) <= 0),
    "backward result with positive velocity")
  `BDVR_ASSERT(a_shadow_range, clk, rst_n,
    (st_r.shadow_speed <= 0) && (st_r.shadow_speed >= -bdvr_pkg::FULL_SCALE),
    "shadow velocity out of range")

endmodule
